@@ hdl/usm_pkg.sv @@
`default_nettype none
package usm_pkg;

  localparam int CNT_W      = 8;
  localparam int CLAMP_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_W      = 10;
  localparam int ANG_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_COUNT    = 3'd0,
    CFG_SEGMENT_COUNT = 3'd1,
    CFG_SPHERE_RADIUS = 3'd2,
    CFG_CENTER_X      = 3'd3,
    CFG_CENTER_Y      = 3'd4,
    CFG_CENTER_Z      = 3'd5,
    CFG_BASE_INDEX    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [CLAMP_W-1:0] rings;
    logic [CLAMP_W-1:0] segs;
    logic [22:0]        radius;
    logic [23:0]        cx;
    logic [23:0]        cy;
    logic [23:0]        cz;
    logic [23:0]        base;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_DIV_LAT, OP_DIV_AZ, OP_CORDIC,
    OP_MUL_ST, OP_WB_ST, OP_MUL_CT, OP_WB_CT,
    OP_MUL_SP, OP_WB_SP, OP_MUL_CP, OP_WB_CP, OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_LAT, ST_COR_LAT, ST_DIV_AZ, ST_COR_AZ,
    ST_MUL_ST, ST_WB_ST, ST_MUL_CT, ST_WB_CT,
    ST_MUL_SP, ST_WB_SP, ST_MUL_CP, ST_WB_CP, ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e           op;
    logic             face;
    logic             second;
    logic [CNT_W-1:0] ring;
    logic [CNT_W-1:0] seg;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cordic_busy;
    logic out_full;
  } dp_stat_t;

  function automatic logic [CLAMP_W-1:0] clamp_count(input logic [6:0] v,
                                                     input int unsigned hi);
    logic [CLAMP_W-1:0] r;
    if (v < 7'd3) begin
      r = CLAMP_W'(3);
    end else if (32'(v) > hi) begin
      r = CLAMP_W'(hi);
    end else begin
      r = CLAMP_W'(v);
    end
    return r;
  endfunction

  function automatic logic [23:0] sat24(input logic signed [26:0] v);
    logic [23:0] r;
    if (v > 27'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -27'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458908;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/usm_if.sv @@
`default_nettype none
interface usm_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface usm_out_if;
  logic        valid;
  logic        ready;
  logic        element_kind;
  logic [23:0] pos_x;
  logic [23:0] pos_y;
  logic [23:0] pos_z;
  logic [23:0] corner_a;
  logic [23:0] corner_b;
  logic [23:0] corner_c;
  logic        final_element;
  modport source (output valid, output element_kind, output pos_x, output pos_y,
                  output pos_z, output corner_a, output corner_b, output corner_c,
                  output final_element, input ready);
  modport sink (input valid, input element_kind, input pos_x, input pos_y,
                input pos_z, input corner_a, input corner_b, input corner_c,
                input final_element, output ready);
endinterface
`default_nettype wire

@@ hdl/usm_cordic.sv @@
`default_nettype none
module usm_cordic import usm_pkg::*; #(
  parameter int F = 15
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ANG_W-1:0]      angle_i,
  output      logic signed [F+2:0]   cos_o,
  output      logic signed [F+2:0]   sin_o,
  output      logic                  busy_o
);

  localparam int XW    = F + 3;
  localparam int STEPS = F + 1;
  localparam int IW    = $clog2(STEPS);
  localparam int X0    = (652032874 + (1 << (29 - F))) >> (30 - F);
  localparam logic signed [33:0] QTR  = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF = 34'sh0_8000_0000;

  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [33:0]   z_q, z_d, z_in, atan_s;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic                 neg_q, neg_d, busy_q, busy_d;

  always_comb begin
    z_in   = {{2{angle_i[ANG_W-1]}}, angle_i};
    atan_s = $signed({4'b0, atan_turn(5'(cnt_q))});
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    if (start_i) begin
      x_d    = XW'(X0);
      y_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      if (z_in > QTR) begin
        z_d   = z_in - HALF;
        neg_d = 1'b1;
      end else if (z_in < -QTR) begin
        z_d   = z_in + HALF;
        neg_d = 1'b1;
      end else begin
        z_d   = z_in;
        neg_d = 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - (y_q >>> cnt_q);
        y_d = y_q + (x_q >>> cnt_q);
        z_d = z_q - atan_s;
      end else begin
        x_d = x_q + (y_q >>> cnt_q);
        y_d = y_q - (x_q >>> cnt_q);
        z_d = z_q + atan_s;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == IW'(STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;
  assign busy_o = busy_q;

endmodule
`default_nettype wire

@@ hdl/usm_dp.sv @@
`default_nettype none
module usm_dp import usm_pkg::*; #(
  parameter int F = 15
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire dp_cmd_t cmd_i,
  input  wire cfg_t    cfg_i,
  output      dp_stat_t stat_o,
  usm_out_if.source    out_o
);

  localparam int XW = F + 3;
  localparam int PW = XW + 25;
  localparam logic signed [PW:0] RND_HALF = (PW+1)'(1) <<< (F - 1);

  // divider: floor((n << 32) / d) modulo 2^32
  logic [DIV_W-1:0] rem_q, dvs_q, shl;
  logic [ANG_W-1:0] quo_q;
  logic [4:0]       dcnt_q;
  logic             div_busy_q;

  assign shl = {rem_q[DIV_W-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (cmd_i.op == OP_DIV_LAT || cmd_i.op == OP_DIV_AZ) begin
      div_busy_q <= 1'b1;
    end else if (div_busy_q && rem_q < dvs_q && dcnt_q == 5'd31) begin
      div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_LAT) begin
      rem_q  <= DIV_W'(cmd_i.ring);
      dvs_q  <= DIV_W'({cfg_i.rings - 1'b1, 1'b0});
      dcnt_q <= '0;
    end else if (cmd_i.op == OP_DIV_AZ) begin
      rem_q  <= DIV_W'(cmd_i.seg);
      dvs_q  <= DIV_W'(cfg_i.segs);
      dcnt_q <= '0;
    end else if (div_busy_q) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
      end else begin
        if (shl >= dvs_q) begin
          rem_q <= shl - dvs_q;
          quo_q <= {quo_q[ANG_W-2:0], 1'b1};
        end else begin
          rem_q <= shl;
          quo_q <= {quo_q[ANG_W-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 1'b1;
      end
    end
  end

  logic signed [XW-1:0] cos_w, sin_w, ct_q, st_q;
  logic                 cordic_busy;

  usm_cordic #(.F(F)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_CORDIC),
    .angle_i (quo_q),
    .cos_o   (cos_w),
    .sin_o   (sin_w),
    .busy_o  (cordic_busy)
  );

  logic signed [XW-1:0] mul_a;
  logic signed [24:0]   mul_b, r25, d_q;
  logic signed [PW-1:0] mul_p, prod_q;
  logic signed [PW:0]   rnd_in, rnd_out;
  logic signed [26:0]   cx27, cy27, cz27;
  logic [23:0]          px_q, py_q, pz_q;

  assign r25  = $signed({2'b0, cfg_i.radius});
  assign cx27 = $signed({{3{cfg_i.cx[23]}}, cfg_i.cx});
  assign cy27 = $signed({{3{cfg_i.cy[23]}}, cfg_i.cy});
  assign cz27 = $signed({{3{cfg_i.cz[23]}}, cfg_i.cz});

  always_comb begin
    unique case (cmd_i.op)
      OP_MUL_CT: begin
        mul_a = ct_q;
        mul_b = r25;
      end
      OP_MUL_SP: begin
        mul_a = sin_w;
        mul_b = d_q;
      end
      OP_MUL_CP: begin
        mul_a = cos_w;
        mul_b = d_q;
      end
      default: begin
        mul_a = st_q;
        mul_b = r25;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign rnd_in  = (cmd_i.op == OP_WB_SP) ? -{prod_q[PW-1], prod_q}
                                          : {prod_q[PW-1], prod_q};
  assign rnd_out = (rnd_in + RND_HALF) >>> F;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_AZ) begin
      ct_q <= cos_w;
      st_q <= sin_w;
    end
    if (cmd_i.op == OP_MUL_ST || cmd_i.op == OP_MUL_CT ||
        cmd_i.op == OP_MUL_SP || cmd_i.op == OP_MUL_CP) begin
      prod_q <= mul_p;
    end
    if (cmd_i.op == OP_WB_ST) begin
      d_q <= rnd_out[24:0];
    end
    if (cmd_i.op == OP_WB_CT) begin
      py_q <= sat24(cy27 + rnd_out[26:0]);
    end
    if (cmd_i.op == OP_WB_SP) begin
      px_q <= sat24(cx27 + rnd_out[26:0]);
    end
    if (cmd_i.op == OP_WB_CP) begin
      pz_q <= sat24(cz27 + rnd_out[26:0]);
    end
  end

  // result of the current element
  logic [CLAMP_W-1:0] ring9, seg_inc;
  logic [23:0]        i24, j24, s24, v24, last24, a_w, b_w, c_w;
  logic [23:0]        rx, ry, rz;
  logic [17:0]        last_mul, v_mul;
  logic               fin_w;

  always_comb begin
    ring9    = CLAMP_W'(cmd_i.ring);
    seg_inc  = CLAMP_W'(cmd_i.seg) + 1'b1;
    i24      = 24'(cmd_i.seg);
    j24      = (seg_inc < cfg_i.segs) ? 24'(seg_inc) : 24'd0;
    s24      = 24'(cfg_i.segs);
    last_mul = (cfg_i.rings - 2'd2) * cfg_i.segs;
    v_mul    = (ring9 - 1'b1) * cfg_i.segs;
    last24   = 24'(last_mul) + 24'd1;
    v24      = cfg_i.base + 24'd1 + 24'(v_mul);
    a_w      = '0;
    b_w      = '0;
    c_w      = '0;
    fin_w    = 1'b0;
    rx       = px_q;
    ry       = py_q;
    rz       = pz_q;
    if (!cmd_i.face) begin
      if (cmd_i.ring == '0) begin
        rx = cfg_i.cx;
        ry = sat24(cy27 + r25);
        rz = cfg_i.cz;
      end else if (ring9 >= cfg_i.rings - 1'b1) begin
        rx = cfg_i.cx;
        ry = sat24(cy27 - r25);
        rz = cfg_i.cz;
      end
    end else begin
      rx = '0;
      ry = '0;
      rz = '0;
      if (cmd_i.ring == '0) begin
        a_w = cfg_i.base;
        b_w = cfg_i.base + 24'd1 + j24;
        c_w = cfg_i.base + 24'd1 + i24;
      end else if (ring9 >= cfg_i.rings - 2'd2) begin
        a_w   = cfg_i.base + last24 - s24 + i24;
        b_w   = cfg_i.base + last24 - s24 + j24;
        c_w   = cfg_i.base + last24;
        fin_w = seg_inc >= cfg_i.segs;
      end else if (!cmd_i.second) begin
        a_w = v24 + i24;
        b_w = v24 + j24;
        c_w = v24 + j24 + s24;
      end else begin
        a_w = v24 + i24;
        b_w = v24 + j24 + s24;
        c_w = v24 + i24 + s24;
      end
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_o.element_kind  <= cmd_i.face;
      out_o.pos_x         <= rx;
      out_o.pos_y         <= ry;
      out_o.pos_z         <= rz;
      out_o.corner_a      <= a_w;
      out_o.corner_b      <= b_w;
      out_o.corner_c      <= c_w;
      out_o.final_element <= fin_w;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign stat_o.div_busy    = div_busy_q;
  assign stat_o.cordic_busy = cordic_busy;
  assign stat_o.out_full    = out_valid_q && !out_o.ready;

endmodule
`default_nettype wire

@@ hdl/usm_ctrl.sv @@
`default_nettype none
module usm_ctrl import usm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  usm_in_if.sink        in_i,
  input  wire cfg_t     cfg_i,
  input  wire dp_stat_t stat_i,
  output      dp_cmd_t  cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic             running_q, running_d, face_q, face_d, tri_q, tri_d;
  logic [CNT_W-1:0] ring_q, ring_d, seg_q, seg_d;
  logic [CLAMP_W-1:0] ring9, seg_inc, ring_inc;
  logic             seg_last;
  dp_op_e           op;

  assign ring9    = CLAMP_W'(ring_q);
  assign ring_inc = ring9 + 1'b1;
  assign seg_inc  = CLAMP_W'(seg_q) + 1'b1;
  assign seg_last = seg_inc >= cfg_i.segs;

  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    face_d    = face_q;
    tri_d     = tri_q;
    ring_d    = ring_q;
    seg_d     = seg_q;
    op        = OP_NONE;
    in_i.ready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.restart) begin
            running_d = 1'b1;
            face_d    = 1'b0;
            tri_d     = 1'b0;
            ring_d    = '0;
            seg_d     = '0;
          end else if (running_q) begin
            if (!face_q && ring_q != '0 && ring9 < cfg_i.rings - 1'b1) begin
              op      = OP_DIV_LAT;
              state_d = ST_DIV_LAT;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_DIV_LAT: begin
        if (!stat_i.div_busy) begin
          op      = OP_CORDIC;
          state_d = ST_COR_LAT;
        end
      end
      ST_COR_LAT: begin
        if (!stat_i.cordic_busy) begin
          op      = OP_DIV_AZ;
          state_d = ST_DIV_AZ;
        end
      end
      ST_DIV_AZ: begin
        if (!stat_i.div_busy) begin
          op      = OP_CORDIC;
          state_d = ST_COR_AZ;
        end
      end
      ST_COR_AZ: begin
        if (!stat_i.cordic_busy) begin
          state_d = ST_MUL_ST;
        end
      end
      ST_MUL_ST: begin
        op      = OP_MUL_ST;
        state_d = ST_WB_ST;
      end
      ST_WB_ST: begin
        op      = OP_WB_ST;
        state_d = ST_MUL_CT;
      end
      ST_MUL_CT: begin
        op      = OP_MUL_CT;
        state_d = ST_WB_CT;
      end
      ST_WB_CT: begin
        op      = OP_WB_CT;
        state_d = ST_MUL_SP;
      end
      ST_MUL_SP: begin
        op      = OP_MUL_SP;
        state_d = ST_WB_SP;
      end
      ST_WB_SP: begin
        op      = OP_WB_SP;
        state_d = ST_MUL_CP;
      end
      ST_MUL_CP: begin
        op      = OP_MUL_CP;
        state_d = ST_WB_CP;
      end
      ST_WB_CP: begin
        op      = OP_WB_CP;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat_i.out_full) begin
          op      = OP_EMIT;
          state_d = ST_IDLE;
          if (!face_q) begin
            if (ring_q == '0) begin
              ring_d = CNT_W'(1);
              seg_d  = '0;
            end else if (ring9 >= cfg_i.rings - 1'b1) begin
              face_d = 1'b1;
              ring_d = '0;
              seg_d  = '0;
              tri_d  = 1'b0;
            end else if (seg_last) begin
              seg_d  = '0;
              ring_d = ring_inc[CNT_W-1:0];
            end else begin
              seg_d = seg_inc[CNT_W-1:0];
            end
          end else if (ring_q == '0) begin
            if (seg_last) begin
              seg_d  = '0;
              ring_d = CNT_W'(1);
            end else begin
              seg_d = seg_inc[CNT_W-1:0];
            end
          end else if (ring9 >= cfg_i.rings - 2'd2) begin
            if (seg_last) begin
              running_d = 1'b0;
            end else begin
              seg_d = seg_inc[CNT_W-1:0];
            end
          end else if (!tri_q) begin
            tri_d = 1'b1;
          end else begin
            tri_d = 1'b0;
            if (seg_last) begin
              seg_d  = '0;
              ring_d = ring_inc[CNT_W-1:0];
            end else begin
              seg_d = seg_inc[CNT_W-1:0];
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      running_q <= 1'b0;
      face_q    <= 1'b0;
      tri_q     <= 1'b0;
      ring_q    <= '0;
      seg_q     <= '0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      face_q    <= face_d;
      tri_q     <= tri_d;
      ring_q    <= ring_d;
      seg_q     <= seg_d;
    end
  end

  assign cmd_o.op     = op;
  assign cmd_o.face   = face_q;
  assign cmd_o.second = tri_q;
  assign cmd_o.ring   = ring_q;
  assign cmd_o.seg    = seg_q;

  a_cordic_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op == OP_CORDIC |-> !stat_i.div_busy)
    else $error("cordic started while divider busy");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op == OP_EMIT |-> !stat_i.out_full)
    else $error("result loaded into full output register");

  a_busy_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> running_q)
    else $error("element in progress while not running");

endmodule
`default_nettype wire

@@ hdl/uv_sphere_mesh_generator_unit.sv @@
`default_nettype none
// Channel   Dir  Payload                                          Accepted when
// item_i    in   restart                                          valid & ready
// elem_o    out  element_kind, pos_x/y/z, corner_a/b/c, final     valid & ready
// cfg       in   cfg_index_i, cfg_data_i                          cfg_we_i
//
// Pole vertices and faces go from idle straight to the emit state, which loads
// the result register; a restart only resets the mesh counters. An inner ring
// vertex runs the shared radix-2 divider, then the one shared CORDIC unit, for
// latitude and again for azimuth, then the multiply and write-back steps. Ready
// is high only in idle, so a transaction reaches its emit before the next is taken.
// Async active-low reset; no clearing pass. A held result stalls only the
// next load; a new transaction is taken while it waits.
module uv_sphere_mesh_generator_unit import usm_pkg::*; #(
  parameter int MAX_RINGS          = 64,
  parameter int MAX_SEGMENTS       = 64,
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  usm_in_if.sink                     item_i,
  usm_out_if.source                  elem_o
);

  logic [6:0]  ring_count_q, segment_count_q;
  logic [22:0] radius_q;
  logic [23:0] cx_q, cy_q, cz_q, base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q    <= 7'd10;
      segment_count_q <= 7'd10;
      radius_q        <= 23'd2560;
      cx_q            <= '0;
      cy_q            <= '0;
      cz_q            <= '0;
      base_q          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RING_COUNT:    ring_count_q    <= cfg_data_i[6:0];
        CFG_SEGMENT_COUNT: segment_count_q <= cfg_data_i[6:0];
        CFG_SPHERE_RADIUS: radius_q        <= cfg_data_i[22:0];
        CFG_CENTER_X:      cx_q            <= cfg_data_i;
        CFG_CENTER_Y:      cy_q            <= cfg_data_i;
        CFG_CENTER_Z:      cz_q            <= cfg_data_i;
        CFG_BASE_INDEX:    base_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.rings  = clamp_count(ring_count_q, MAX_RINGS);
  assign cfg.segs   = clamp_count(segment_count_q, MAX_SEGMENTS);
  assign cfg.radius = radius_q;
  assign cfg.cx     = cx_q;
  assign cfg.cy     = cy_q;
  assign cfg.cz     = cz_q;
  assign cfg.base   = base_q;

  usm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_i),
    .cfg_i  (cfg),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  usm_dp #(.F(TRIG_FRACTION_BITS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .stat_o (stat),
    .out_o  (elem_o)
  );

endmodule
`default_nettype wire

@@ dv/uv_sphere_mesh_generator_unit_checker.sv @@
`default_nettype none
module uv_sphere_mesh_generator_unit_checker import usm_pkg::*; #(
  parameter int MAX_RINGS          = 64,
  parameter int MAX_SEGMENTS       = 64,
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  usm_in_if                          item_if,
  usm_out_if                         elem_if,
  output int                         errors_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F = TRIG_FRACTION_BITS;

  typedef struct {
    logic        kind;
    logic [23:0] px, py, pz;
    logic [23:0] ca, cb, cc;
    logic        fin;
  } mesh_elem_t;

  localparam longint ATAN_TURN [0:31] = '{
    536870912, 316933406, 167458908, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  mesh_elem_t  mesh_q[$];
  logic [6:0]  ring_cnt, seg_cnt;
  logic [22:0] radius;
  logic [23:0] cen_x, cen_y, cen_z, base_idx;
  bit          gen_on, in_faces, tri2;
  int unsigned ring_ctr, seg_ctr;
  int          errors;

  function automatic longint round_q(input longint p);
    return (p + (longint'(1) << (F - 1))) >>> F;
  endfunction

  function automatic logic [23:0] clip24(input longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic int unsigned clampc(input logic [6:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'({32'b0, ang});
    if (ang[31]) z = z - 64'sd4294967296;
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    x = (64'sd652032874 + (longint'(1) << (29 - F))) >>> (30 - F);
    y = 0;
    for (int i = 0; i < F + 1 && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic mesh_tick(input logic rs);
    int unsigned rings, segs, ring, i, j;
    longint      r, cx, cy, cz, px, py, pz, ct, st, cp, sp, d;
    longint      a, b, c, v, last;
    logic [31:0] lat, az;
    mesh_elem_t  e;
    rings = clampc(ring_cnt, MAX_RINGS);
    segs  = clampc(seg_cnt, MAX_SEGMENTS);
    r  = longint'({1'b0, radius});
    cx = longint'($signed(cen_x));
    cy = longint'($signed(cen_y));
    cz = longint'($signed(cen_z));
    ring = ring_ctr;
    i = seg_ctr;
    e = '{kind: 0, px: 0, py: 0, pz: 0, ca: 0, cb: 0, cc: 0, fin: 0};
    if (rs) begin
      gen_on = 1; in_faces = 0; tri2 = 0; ring_ctr = 0; seg_ctr = 0;
      return;
    end
    if (!gen_on) return;
    if (!in_faces) begin
      px = cx;
      pz = cz;
      if (ring == 0) begin
        py = cy + r;
        ring_ctr = 1; seg_ctr = 0;
      end else if (ring >= rings - 1) begin
        py = cy - r;
        in_faces = 1; ring_ctr = 0; seg_ctr = 0; tri2 = 0;
      end else begin
        lat = 32'((longint'(ring) << 31) / (rings - 1));
        az  = 32'((longint'(i) << 32) / segs);
        sincos(lat, ct, st);
        sincos(az, cp, sp);
        d  = round_q(st * r);
        py = cy + round_q(ct * r);
        px = cx + round_q(-(sp * d));
        pz = cz + round_q(cp * d);
        if (i + 1 >= segs) begin
          seg_ctr = 0; ring_ctr = ring + 1;
        end else begin
          seg_ctr = i + 1;
        end
      end
      e.px = clip24(px);
      e.py = clip24(py);
      e.pz = clip24(pz);
      mesh_q.push_back(e);
      return;
    end
    j = (i + 1 < segs) ? i + 1 : 0;
    if (ring == 0) begin
      a = base_idx;
      b = base_idx + 1 + j;
      c = base_idx + 1 + i;
      if (i + 1 >= segs) begin
        seg_ctr = 0; ring_ctr = 1;
      end else begin
        seg_ctr = i + 1;
      end
    end else if (ring >= rings - 2) begin
      last = 1 + longint'(rings - 2) * segs;
      a = base_idx + last - segs + i;
      b = base_idx + last - segs + j;
      c = base_idx + last;
      if (i + 1 >= segs) begin
        e.fin = 1; gen_on = 0;
      end else begin
        seg_ctr = i + 1;
      end
    end else begin
      v = base_idx + 1 + longint'(ring - 1) * segs;
      if (!tri2) begin
        a = v + i; b = v + j; c = v + j + segs;
        tri2 = 1;
      end else begin
        a = v + i; b = v + j + segs; c = v + i + segs;
        tri2 = 0;
        if (i + 1 >= segs) begin
          seg_ctr = 0; ring_ctr = ring + 1;
        end else begin
          seg_ctr = i + 1;
        end
      end
    end
    e.kind = 1;
    e.ca = a[23:0];
    e.cb = b[23:0];
    e.cc = c[23:0];
    mesh_q.push_back(e);
  endtask

  task automatic check_elem();
    mesh_elem_t  e;
    logic [23:0] want [8];
    logic [23:0] got [8];
    string       fname [8];
    bit          bad;
    fname = '{"element_kind", "pos_x", "pos_y", "pos_z",
              "corner_a", "corner_b", "corner_c", "final_element"};
    if (mesh_q.size() == 0) begin
      if (errors < 10) $display("%0t: element with nothing expected", $realtime);
      errors++;
      return;
    end
    e = mesh_q.pop_front();
    want = '{24'(e.kind), e.px, e.py, e.pz, e.ca, e.cb, e.cc, 24'(e.fin)};
    got  = '{24'(elem_if.element_kind), elem_if.pos_x, elem_if.pos_y, elem_if.pos_z,
             elem_if.corner_a, elem_if.corner_b, elem_if.corner_c,
             24'(elem_if.final_element)};
    bad = 0;
    for (int k = 0; k < 8; k++) begin
      if (want[k] !== got[k]) begin
        if (errors < 10) begin
          $display("%0t: %s expected %h got %h", $realtime, fname[k], want[k], got[k]);
        end
        bad = 1;
      end
    end
    if (bad) errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cnt = 10; seg_cnt = 10; radius = 2560;
      cen_x = 0; cen_y = 0; cen_z = 0; base_idx = 0;
      gen_on = 0; in_faces = 0; tri2 = 0; ring_ctr = 0; seg_ctr = 0;
      mesh_q.delete();
    end else begin
      if (elem_if.valid && elem_if.ready) check_elem();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RING_COUNT:    ring_cnt = cfg_data_i[6:0];
          CFG_SEGMENT_COUNT: seg_cnt  = cfg_data_i[6:0];
          CFG_SPHERE_RADIUS: radius   = cfg_data_i[22:0];
          CFG_CENTER_X:      cen_x    = cfg_data_i;
          CFG_CENTER_Y:      cen_y    = cfg_data_i;
          CFG_CENTER_Z:      cen_z    = cfg_data_i;
          CFG_BASE_INDEX:    base_idx = cfg_data_i;
          default: ;
        endcase
      end
      if (item_if.valid && item_if.ready) mesh_tick(item_if.restart);
    end
    errors_o  = errors;
    pending_o = mesh_q.size();
  end

  initial errors = 0;
endmodule
`default_nettype wire

@@ dv/uv_sphere_mesh_generator_unit_tb.sv @@
`default_nettype none
module uv_sphere_mesh_generator_unit_tb import usm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1000000;
  localparam int DRAIN = 200;

  logic                  clk_i, rst_ni, cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors, pending, cycles, items;
  int                    in_idle_pct, out_idle_pct, hold_cnt;
  int unsigned           rings_now, segs_now;

  usm_in_if  item_if();
  usm_out_if elem_if();

  uv_sphere_mesh_generator_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .item_i(item_if), .elem_o(elem_if));

  uv_sphere_mesh_generator_unit_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .item_if, .elem_if, .errors_o(errors), .pending_o(pending));

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("uv_sphere_mesh_generator_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    elem_if.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        elem_if.ready <= 0;
        hold_cnt--;
      end else begin
        elem_if.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic int unsigned clampc(input logic [6:0] v);
    if (v < 3) return 3;
    if (v > 64) return 64;
    return 32'(v);
  endfunction

  task automatic send_item(input logic rs);
    if ($urandom_range(99) < in_idle_pct) begin
      item_if.valid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk_i);
    end
    item_if.valid   <= 1;
    item_if.restart <= rs;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    item_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [23:0] d);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
  endtask

  task automatic set_mesh(input logic [6:0] r, input logic [6:0] s, input logic [22:0] rad,
                          input logic [23:0] cx, input logic [23:0] cy,
                          input logic [23:0] cz, input logic [23:0] base);
    write_reg(CFG_RING_COUNT, 24'(r));
    write_reg(CFG_SEGMENT_COUNT, 24'(s));
    write_reg(CFG_SPHERE_RADIUS, 24'(rad));
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_BASE_INDEX, base);
    cfg_we <= 0;
    @(posedge clk_i);
    rings_now = clampc(r);
    segs_now  = clampc(s);
  endtask

  // restart, then up to n element requests; n beyond the mesh adds idle ticks
  task automatic run_mesh(input int n);
    int total;
    total = 2 + (rings_now - 2) * segs_now + 2 * segs_now + 2 * (rings_now - 3) * segs_now;
    send_item(1);
    items++;
    for (int k = 0; k < n; k++) begin
      send_item(0);
      if (k < total) items++;
    end
  endtask

  function automatic logic [23:0] rand_center();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'h7FFFFF - 24'($urandom_range(255));
      2: return 24'h800000 + 24'($urandom_range(255));
      default: return 24'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic logic [6:0] rand_count();
    int p;
    p = $urandom_range(99);
    if (p < 80) return 7'($urandom_range(6, 3));
    if (p < 90) return 7'($urandom_range(2));
    return 7'($urandom_range(127, 7));
  endfunction

  initial begin
    int          phase, total, n;
    logic [22:0] rad;
    rst_ni = 0;
    cfg_we = 0;
    cfg_index = CFG_RING_COUNT;
    cfg_data = 0;
    item_if.valid = 0;
    item_if.restart = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cnt = 0;
    items = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // idle tick before any restart
    send_item(0);
    drain();
    set_mesh(3, 3, 2560, 0, 0, 0, 0);
    run_mesh(12);
    drain();
    // clamped counts, saturating coordinates, index wrap, restart mid-mesh
    set_mesh(0, 127, 23'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd16773119);
    run_mesh(6);
    run_mesh(3);
    drain();
    set_mesh(127, 0, 0, 24'h800000, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    run_mesh(3);
    drain();

    phase = 0;
    while (items < 950) begin
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin in_idle_pct = 65; out_idle_pct = 0;  end
        2: begin in_idle_pct = 0;  out_idle_pct = 65; end
        default: begin in_idle_pct = 34; out_idle_pct = 34; end
      endcase
      case ($urandom_range(3))
        0: rad = 0;
        1: rad = 23'h7FFFFF;
        default: rad = 23'($urandom_range(1 << 20));
      endcase
      set_mesh(rand_count(), rand_count(), rad, rand_center(), rand_center(),
               rand_center(),
               ($urandom_range(3) == 0) ? 24'd16773119 - 24'($urandom_range(200))
                                        : 24'($urandom_range(16773119)));
      total = 2 + (rings_now - 2) * segs_now + 2 * segs_now
              + 2 * (rings_now - 3) * segs_now;
      if (phase == 5) hold_cnt = 400;
      if (total > 80) n = $urandom_range(40, 10);
      else if ($urandom_range(5) == 0) n = $urandom_range(total - 1, 1);
      else n = total + $urandom_range(3) * ($urandom_range(2) == 0);
      run_mesh(n);
      if ($urandom_range(4) == 0) run_mesh($urandom_range(total < 40 ? total : 40, 1));
      drain();
      phase++;
    end

    in_idle_pct = 0;
    out_idle_pct = 0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("uv_sphere_mesh_generator_unit_tb OK");
    end else begin
      $display("uv_sphere_mesh_generator_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
